### rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared types, codes, constants and saturation helpers for the PID core.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam logic [1:0] ACT_FILTERED = 2'd0;
   localparam logic [1:0] ACT_EXTERNAL = 2'd1;
   localparam logic [1:0] ACT_RESTART  = 2'd2;
   localparam logic [1:0] ACT_HOLD     = 2'd3;

   localparam logic [2:0] REG_GAIN_PROP        = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEGRAL    = 3'd1;
   localparam logic [2:0] REG_GAIN_DERIV       = 3'd2;
   localparam logic [2:0] REG_GAIN_FEEDFORWARD = 3'd3;
   localparam logic [2:0] REG_DRIVE_MAX        = 3'd4;
   localparam logic [2:0] REG_DRIVE_MIN        = 3'd5;
   localparam logic [2:0] REG_RAMP_RATE        = 3'd6;
   localparam logic [2:0] REG_FILTER_RATE      = 3'd7;

   localparam logic signed [32:0] DERIV_FILTER_GAIN = 33'sd65536;
   localparam logic signed [63:0] OUTPUT_BIAS       = 64'sd0;

   localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
   localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;
   localparam logic signed [65:0] S48_MAX_W = 66'sd140737488355327;
   localparam logic signed [65:0] S48_MIN_W = -66'sd140737488355328;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_PREP2, ST_COEF, ST_STEP, ST_INT, ST_PROP, ST_DERIV,
      ST_FILT, ST_IHI, ST_ILO, ST_DTERM, ST_FF, ST_RAMP, ST_DRAIN, ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_COEF, MUL_STEP, MUL_INT, MUL_PROP, MUL_DERIV, MUL_FILT,
      MUL_IHI, MUL_ILO, MUL_DTERM, MUL_FF, MUL_RAMP
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       prep;
      logic       prep2;
      mul_op_type mul_op;
      logic       drain;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       out_free;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX_W) r = 32'sh7fffffff;
      else if (v < S32_MIN_W) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
      logic signed [47:0] r;
      if (v > S48_MAX_W) r = 48'sh7fffffffffff;
      else if (v < S48_MIN_W) r = 48'sh800000000000;
      else r = v[47:0];
      return r;
   endfunction

endpackage

### rtl/pidc_req_if.sv
// ----------------------------------------------------------------------------
// PID request channel
// Valid/ready channel carrying one controller sample.
// ----------------------------------------------------------------------------
interface pidc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] setpoint;
   logic signed [31:0] measured;
   logic signed [31:0] rate_in;
   logic [31:0]        time_stamp;

   modport source (output valid, action, setpoint, measured, rate_in, time_stamp,
                   input ready);
   modport sink (input valid, action, setpoint, measured, rate_in, time_stamp,
                 output ready);
endinterface

### rtl/pidc_rsp_if.sv
// ----------------------------------------------------------------------------
// PID response channel
// Valid/ready channel carrying one controller result.
// ----------------------------------------------------------------------------
interface pidc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive;
   logic               integration_held;

   modport source (output valid, drive, integration_held, input ready);
   modport sink (input valid, drive, integration_held, output ready);
endinterface

### rtl/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// PID sequencer
// Steps one request through the shared multiplier schedule.
// ----------------------------------------------------------------------------
module pidc_ctrl
   import pidc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      filtered;

   assign filtered = (status.action == ACT_FILTERED);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_PREP;
         ST_PREP: begin
            if (status.action == ACT_RESTART || status.action == ACT_HOLD)
               state_in = ST_FIN;
            else
               state_in = ST_PREP2;
         end
         ST_PREP2: state_in = filtered ? ST_COEF : ST_INT;
         ST_COEF:  state_in = ST_STEP;
         ST_STEP:  state_in = ST_INT;
         ST_INT:   state_in = ST_PROP;
         ST_PROP:  state_in = filtered ? ST_DERIV : ST_IHI;
         ST_DERIV: state_in = ST_FILT;
         ST_FILT:  state_in = ST_IHI;
         ST_IHI:   state_in = ST_ILO;
         ST_ILO:   state_in = ST_DTERM;
         ST_DTERM: state_in = ST_FF;
         ST_FF:    state_in = ST_RAMP;
         ST_RAMP:  state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_FIN;
         ST_FIN:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd        = '0;
      cmd.mul_op = MUL_NONE;
      unique case (state_ff)
         ST_IDLE:  cmd.load = req_valid;
         ST_PREP:  cmd.prep = 1'b1;
         ST_PREP2: cmd.prep2 = 1'b1;
         ST_COEF:  cmd.mul_op = MUL_COEF;
         ST_STEP:  cmd.mul_op = MUL_STEP;
         ST_INT:   cmd.mul_op = MUL_INT;
         ST_PROP:  cmd.mul_op = MUL_PROP;
         ST_DERIV: cmd.mul_op = MUL_DERIV;
         ST_FILT:  cmd.mul_op = MUL_FILT;
         ST_IHI:   cmd.mul_op = MUL_IHI;
         ST_ILO:   cmd.mul_op = MUL_ILO;
         ST_DTERM: cmd.mul_op = MUL_DTERM;
         ST_FF:    cmd.mul_op = MUL_FF;
         ST_RAMP:  cmd.mul_op = MUL_RAMP;
         ST_DRAIN: cmd.drain = 1'b1;
         ST_FIN:   cmd.fin = status.out_free;
         default:  cmd.load = 1'b0;
      endcase
   end

endmodule

### rtl/pidc_datapath.sv
// ----------------------------------------------------------------------------
// PID datapath
// Registers, shared 33x33 multiplier, controller state and result register.
// ----------------------------------------------------------------------------
module pidc_datapath
   import pidc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_setpoint,
   input  logic signed [31:0] req_measured,
   input  logic signed [31:0] req_rate_in,
   input  logic [31:0]        req_time_stamp,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_integration_held
);

   logic signed [31:0] gain_prop_ff, gain_integral_ff, gain_deriv_ff, gain_ff_ff;
   logic signed [31:0] drive_max_ff, drive_min_ff;
   logic [30:0]        ramp_rate_ff, filter_rate_ff;

   logic [31:0]        last_time_ff;
   logic signed [31:0] last_error_ff, filter_ff, last_drive_ff;
   logic signed [47:0] integral_ff;

   logic [1:0]         action_ff;
   logic signed [31:0] setpoint_ff, measured_ff, rate_in_ff;
   logic [31:0]        time_ff;
   logic signed [31:0] err_ff, mean_ff, coef_ff, step_ff, deriv_ff, lim_ff;
   logic signed [32:0] dt_ff, diff_ff;
   logic               held_ff;
   logic signed [63:0] ihi_ff, acc_ff;
   logic signed [47:0] iterm_ff;
   logic signed [49:0] ramp_ff;

   logic signed [65:0] prod_ff;
   mul_op_type         tag_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] drive_ff;
   logic               held_out_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [49:0] psh;
   logic signed [65:0] sum_w, lim_w, up_w, down_w, drv_w;
   logic signed [32:0] mean_w;
   logic               gneg, gpos, held_in;
   logic signed [31:0] drive_in;

   assign psh = prod_ff[65:16];
   assign status.action   = action_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.mul_op)
         MUL_COEF:  begin mul_a = DERIV_FILTER_GAIN; mul_b = {2'b0, filter_rate_ff}; end
         MUL_STEP:  begin mul_a = dt_ff; mul_b = {2'b0, filter_rate_ff}; end
         MUL_INT:   begin mul_a = 33'(mean_ff); mul_b = dt_ff; end
         MUL_PROP:  begin mul_a = 33'(gain_prop_ff); mul_b = 33'(err_ff); end
         MUL_DERIV: begin mul_a = 33'(coef_ff); mul_b = diff_ff; end
         MUL_FILT:  begin mul_a = 33'(step_ff); mul_b = diff_ff; end
         MUL_IHI: begin
            mul_a = 33'(gain_integral_ff);
            mul_b = 33'($signed(integral_ff[47:16]));
         end
         MUL_ILO: begin
            mul_a = 33'(gain_integral_ff);
            mul_b = {17'b0, integral_ff[15:0]};
         end
         MUL_DTERM: begin mul_a = 33'(gain_deriv_ff); mul_b = 33'(deriv_ff); end
         MUL_FF:    begin mul_a = 33'(gain_ff_ff); mul_b = 33'(setpoint_ff); end
         MUL_RAMP:  begin mul_a = dt_ff; mul_b = {2'b0, ramp_rate_ff}; end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      gneg    = (err_ff != 0) && (gain_integral_ff != 0) &&
                (err_ff[31] != gain_integral_ff[31]);
      gpos    = (err_ff != 0) && (gain_integral_ff != 0) &&
                (err_ff[31] == gain_integral_ff[31]);
      held_in = !((last_drive_ff < drive_max_ff || gneg) &&
                  (last_drive_ff > drive_min_ff || gpos));
      mean_w  = (33'(last_error_ff) + 33'(err_ff)) >>> 1;

      sum_w = 66'(acc_ff) + 66'(iterm_ff);
      lim_w = (sum_w > 66'(drive_max_ff)) ? 66'(drive_max_ff) : sum_w;
      if (lim_w < 66'(drive_min_ff)) lim_w = 66'(drive_min_ff);

      up_w   = 66'(last_drive_ff) + 66'(ramp_ff);
      down_w = 66'(last_drive_ff) - 66'(ramp_ff);
      drv_w  = 66'(lim_ff);
      if (drv_w > up_w) drv_w = up_w;
      if (drv_w < down_w) drv_w = down_w;

      unique case (action_ff)
         ACT_RESTART: drive_in = '0;
         ACT_HOLD:    drive_in = last_drive_ff;
         default:     drive_in = sat32(drv_w);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff     <= '0;
         gain_integral_ff <= '0;
         gain_deriv_ff    <= '0;
         gain_ff_ff       <= '0;
         drive_max_ff     <= '0;
         drive_min_ff     <= '0;
         ramp_rate_ff     <= '0;
         filter_rate_ff   <= '0;
         last_time_ff     <= '0;
         last_error_ff    <= '0;
         filter_ff        <= '0;
         last_drive_ff    <= '0;
         integral_ff      <= '0;
         tag_ff           <= MUL_NONE;
         rsp_valid_ff     <= 1'b0;
         action_ff        <= ACT_FILTERED;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_GAIN_PROP:        gain_prop_ff     <= csr_data;
               REG_GAIN_INTEGRAL:    gain_integral_ff <= csr_data;
               REG_GAIN_DERIV:       gain_deriv_ff    <= csr_data;
               REG_GAIN_FEEDFORWARD: gain_ff_ff       <= csr_data;
               REG_DRIVE_MAX:        drive_max_ff     <= csr_data;
               REG_DRIVE_MIN:        drive_min_ff     <= csr_data;
               REG_RAMP_RATE:        ramp_rate_ff     <= csr_data[30:0];
               REG_FILTER_RATE:      filter_rate_ff   <= csr_data[30:0];
               default:              gain_prop_ff     <= gain_prop_ff;
            endcase
         end
         tag_ff <= cmd.mul_op;
         if (cmd.load) action_ff <= req_action;
         if (tag_ff == MUL_FILT)
            filter_ff <= sat32(66'(filter_ff) + 66'(psh));
         if (tag_ff == MUL_INT && !held_ff)
            integral_ff <= sat48(66'(integral_ff) + 66'(psh));
         if (cmd.fin) begin
            unique case (action_ff)
               ACT_RESTART: begin
                  last_time_ff  <= time_ff;
                  filter_ff     <= err_ff;
                  integral_ff   <= '0;
                  last_drive_ff <= '0;
               end
               ACT_HOLD: last_drive_ff <= last_drive_ff;
               default: begin
                  last_time_ff  <= time_ff;
                  last_error_ff <= err_ff;
                  last_drive_ff <= drive_in;
               end
            endcase
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load) begin
         setpoint_ff <= req_setpoint;
         measured_ff <= req_measured;
         rate_in_ff  <= req_rate_in;
         time_ff     <= req_time_stamp;
      end
      if (cmd.prep) begin
         err_ff   <= sat32(66'(setpoint_ff) - 66'(measured_ff));
         dt_ff    <= $signed({1'b0, time_ff}) - $signed({1'b0, last_time_ff});
         acc_ff   <= OUTPUT_BIAS;
         deriv_ff <= rate_in_ff;
      end
      if (cmd.prep2) begin
         diff_ff <= 33'(err_ff) - 33'(filter_ff);
         mean_ff <= mean_w[31:0];
         held_ff <= held_in;
      end
      unique case (tag_ff)
         MUL_COEF:  coef_ff  <= sat32(66'(psh));
         MUL_STEP:  step_ff  <= sat32(66'(psh));
         MUL_DERIV: deriv_ff <= sat32(66'(psh));
         MUL_IHI:   ihi_ff   <= prod_ff[63:0];
         MUL_ILO:   iterm_ff <= sat48(66'(ihi_ff) + 66'(psh));
         MUL_PROP, MUL_DTERM, MUL_FF: acc_ff <= acc_ff + 64'(psh);
         MUL_RAMP:  ramp_ff  <= psh;
         default:   ramp_ff  <= ramp_ff;
      endcase
      if (cmd.drain) lim_ff <= lim_w[31:0];
      if (cmd.fin) begin
         drive_ff    <= drive_in;
         held_out_ff <= held_ff &&
                        (action_ff == ACT_FILTERED || action_ff == ACT_EXTERNAL);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive            = drive_ff;
   assign rsp_integration_held = held_out_ff;

endmodule

### rtl/pid_controller_filtered_deriv_core.sv
// ----------------------------------------------------------------------------
// PID controller core with filtered derivative
// Anti-windup PID step with drive clamp and ramp limit, Q16.16.
// ----------------------------------------------------------------------------
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    action, setpoint, measured, rate_in,
//                                       time_stamp
//   rsp_ch    out        valid/ready    drive, integration_held
//   csr_*     in         write enable   csr_index, csr_data
//
// Filtered-derivative step adds coefficient, step, derivative and filter
// products; external velocity step omits them; restart and hold: none.
// One 33x33 multiplier serves every product, one per cycle.
// Synchronous active-high reset; no clearing pass.
// A waiting result holds only the final cycle; the next request is taken
// while a result sits in the output register.
// ----------------------------------------------------------------------------
module pid_controller_filtered_deriv_core
   import pidc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pidc_req_if.sink    req_ch,
   pidc_rsp_if.source  rsp_ch,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pidc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_action           (req_ch.action),
      .req_setpoint         (req_ch.setpoint),
      .req_measured         (req_ch.measured),
      .req_rate_in          (req_ch.rate_in),
      .req_time_stamp       (req_ch.time_stamp),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_ch.valid),
      .rsp_ready            (rsp_ch.ready),
      .rsp_drive            (rsp_ch.drive),
      .rsp_integration_held (rsp_ch.integration_held)
   );

endmodule

### rtl/pidc_checker.sv
// ----------------------------------------------------------------------------
// PID core checker
// Port-level properties of the PID core, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_drive
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_drive))
      else $error("response drive changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind pid_controller_filtered_deriv_core pidc_checker u_pidc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_drive (rsp_ch.drive)
);
